[src/sdf_pkg.sv]
`timescale 1ns / 1ps

package sdf_pkg;

    localparam int DEFAULT_MAX_WIDTH = 64;
    localparam int DIGIT_BUF = 10;
    localparam int DIG_CNT_W = $clog2(DIGIT_BUF + 1);

    localparam int VALUE_W = 32;
    localparam int MIN_WIDTH_W = 7;
    localparam int IN_DATA_W = 40;
    localparam int IN_USER_W = 3;
    localparam int CHAR_W = 8;

    localparam int PROD_W = 64;
    localparam int RECIP_SHIFT = 35;
    localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;

    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIGIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic digit_step;
        logic emit_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic quot_zero;
        logic slot_free;
        logic last_char;
    } dp_status_t;

endpackage

[src/sdf_ctrl.sv]
`timescale 1ns / 1ps

module sdf_ctrl
    import sdf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                state_next = ST_DIGIT;
            end
            ST_DIGIT: begin
                cmd.digit_step = 1'b1;
                if (status.quot_zero) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.slot_free) begin
                    cmd.emit_step = 1'b1;
                    if (status.last_char) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/sdf_datapath.sv]
`timescale 1ns / 1ps

module sdf_datapath
    import sdf_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             status,
    input  logic [VALUE_W-1:0]     value,
    input  logic [MIN_WIDTH_W-1:0] min_width,
    input  logic                   plus_flag,
    input  logic                   space_flag,
    input  logic                   zero_flag,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [CHAR_W-1:0]      out_char,
    output logic                   out_last
);

    localparam int PAD_W = $clog2(MAX_WIDTH + 1);
    localparam int REM_W = PAD_W + 2;

    logic [VALUE_W-1:0]    mag_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [PAD_W-1:0]      pad_cnt_reg;
    logic                  sign_pend_reg;
    logic [CHAR_W-1:0]     sign_ch_reg;
    logic                  zpad_reg;
    logic [DIG_CNT_W-1:0]  dig_cnt_reg;
    logic [3:0]            dig_reg [DIGIT_BUF];
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [CHAR_W-1:0]     out_char_reg;
    logic                  out_last_reg;

    logic                  neg;
    logic [VALUE_W-1:0]    mag_in;
    logic [PAD_W-1:0]      width_sat;
    logic                  sign_in;
    logic [PAD_W-1:0]      pad_init;
    logic [VALUE_W-1:0]    quot;
    logic [VALUE_W-1:0]    mul_in;
    logic [3:0]            rem_digit;
    logic [REM_W-1:0]      remaining;
    logic [CHAR_W-1:0]     emit_char;

    assign neg = value[VALUE_W-1];
    assign mag_in = neg ? (VALUE_W'(0) - value) : value;
    assign width_sat = (min_width > MIN_WIDTH_W'(MAX_WIDTH)) ? PAD_W'(MAX_WIDTH)
                                                             : PAD_W'(min_width);
    assign sign_in = neg | plus_flag | space_flag;
    assign pad_init = (sign_in && width_sat != '0) ? (width_sat - PAD_W'(1)) : width_sat;

    // The quotient by ten is the high part of the reciprocal product.
    assign quot = VALUE_W'(prod_reg[PROD_W-1:RECIP_SHIFT]);
    assign mul_in = cmd.digit_step ? quot : mag_reg;
    assign rem_digit = mag_reg[3:0] - 4'(quot[3:0] * 4'd10);

    assign remaining = REM_W'(pad_cnt_reg) + REM_W'(sign_pend_reg) + REM_W'(dig_cnt_reg);

    always_comb begin
        priority if (!zpad_reg && pad_cnt_reg != '0) begin
            emit_char = CH_SPACE;
        end else if (sign_pend_reg) begin
            emit_char = sign_ch_reg;
        end else if (pad_cnt_reg != '0) begin
            emit_char = CH_ZERO;
        end else begin
            emit_char = CH_ZERO + {4'b0, dig_reg[0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mag_reg <= mag_in;
            pad_cnt_reg <= pad_init;
            sign_pend_reg <= sign_in;
            sign_ch_reg <= neg ? CH_MINUS : (plus_flag ? CH_PLUS : CH_SPACE);
            zpad_reg <= zero_flag;
            dig_cnt_reg <= '0;
        end
        if (cmd.mul_step || cmd.digit_step) begin
            prod_reg <= mul_in * RECIP_TEN;
        end
        if (cmd.digit_step) begin
            mag_reg <= quot;
            dig_cnt_reg <= dig_cnt_reg + DIG_CNT_W'(1);
            if (pad_cnt_reg != '0) begin
                pad_cnt_reg <= pad_cnt_reg - PAD_W'(1);
            end
            dig_reg[0] <= rem_digit;
            for (int i = 1; i < DIGIT_BUF; i++) begin
                dig_reg[i] <= dig_reg[i-1];
            end
        end
        if (cmd.emit_step) begin
            out_char_reg <= emit_char;
            out_last_reg <= (remaining == REM_W'(1));
            priority if (!zpad_reg && pad_cnt_reg != '0) begin
                pad_cnt_reg <= pad_cnt_reg - PAD_W'(1);
            end else if (sign_pend_reg) begin
                sign_pend_reg <= 1'b0;
            end else if (pad_cnt_reg != '0) begin
                pad_cnt_reg <= pad_cnt_reg - PAD_W'(1);
            end else begin
                dig_cnt_reg <= dig_cnt_reg - DIG_CNT_W'(1);
                for (int i = 0; i < DIGIT_BUF - 1; i++) begin
                    dig_reg[i] <= dig_reg[i+1];
                end
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit_step) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.quot_zero = (quot == '0);
    assign status.slot_free = !out_valid_reg || out_ready;
    assign status.last_char = (remaining == REM_W'(1));

    assign out_valid = out_valid_reg;
    assign out_char = out_char_reg;
    assign out_last = out_last_reg;

endmodule

[src/signed_decimal_formatter_top.sv]
// After acceptance the value is loaded and multiplied by the reciprocal of ten; then its d (1 to 10)
// decimal digits come one per cycle from the reciprocal multiplier before the first character is registered.
// An item occupies the block until its last character is sent; characters leave one per cycle
// through the output register while the output is not stalled; the next item is taken after.
// Reset is synchronous and active low; it returns the controller to idle and empties the output.
`timescale 1ns / 1ps

module signed_decimal_formatter_top
    import sdf_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // Fields from bit 0: value[31:0], min_width[38:32], bit 39 unused.
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // Fields from bit 0: plus_flag, space_flag, zero_flag.
    input  logic [IN_USER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // Fields from bit 0: char_out[7:0].
    output logic [CHAR_W-1:0]    m_axis_tdata,
    output logic                 m_axis_tlast
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    sdf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sdf_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .value      (s_axis_tdata[VALUE_W-1:0]),
        .min_width  (s_axis_tdata[VALUE_W+MIN_WIDTH_W-1:VALUE_W]),
        .plus_flag  (s_axis_tuser[0]),
        .space_flag (s_axis_tuser[1]),
        .zero_flag  (s_axis_tuser[2]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_char   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule

[src/sdf_checker.sv]
`timescale 1ns / 1ps

module sdf_checker
    import sdf_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [CHAR_W-1:0]    m_axis_tdata,
    input logic                 m_axis_tlast
);

    // A digit step always follows the multiply setup, so the input stays closed through both.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input reopened during digit conversion");

    // When the block is open for an item, any character still waiting ends the previous text.
    a_idle_only_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tready && m_axis_tvalid) |-> m_axis_tlast)
        else $error("input open while a text is unfinished");

    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata == CH_SPACE || m_axis_tdata == CH_PLUS ||
                           m_axis_tdata == CH_MINUS ||
                           (m_axis_tdata >= CH_ZERO && m_axis_tdata <= 8'h39)))
        else $error("character outside the decimal text set");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output item changed");

endmodule

bind signed_decimal_formatter_top sdf_checker u_sdf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
